// ----- hw/rtl/sfd_pkg.sv -----
// SLIP frame decoder package: byte codes, mode and result kind types.
// No dependencies; used by every other file of the block.
`default_nettype none

package sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int KIND_W  = 2;

    localparam logic [BYTE_W-1:0] SLIP_FEND  = 8'hC0;
    localparam logic [BYTE_W-1:0] SLIP_FESC  = 8'hDB;
    localparam logic [BYTE_W-1:0] SLIP_TFEND = 8'hDC;
    localparam logic [BYTE_W-1:0] SLIP_TFESC = 8'hDD;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        MODE_HUNT  = 3'b001,
        MODE_FRAME = 3'b010,
        MODE_ESC   = 3'b100
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_BADESC  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [COUNT_W-1:0]  payload_count;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_dec_out;

endpackage

`default_nettype wire

// ----- hw/rtl/sfd_byte_if.sv -----
// Byte channel into the SLIP decoder: valid/ready plus one received byte.
// Depends on sfd_pkg.
`default_nettype none

interface sfd_byte_if
    import sfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfd_result_if.sv -----
// Result channel out of the SLIP decoder: valid/ready plus kind, byte, count.
// Depends on sfd_pkg.
`default_nettype none

interface sfd_result_if
    import sfd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] payload_count;

    modport source (output valid, output kind, output data_byte, output payload_count,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input payload_count,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfd_in_stage.sv -----
// Input register of the SLIP decoder: holds one received word.
// Depends on sfd_pkg.
`default_nettype none

module sfd_in_stage
    import sfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_ready,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfd_decode.sv -----
// Framing state machine and byte counter of the SLIP decoder.
// Depends on sfd_pkg; result goes combinationally to sfd_out_stage.
`default_nettype none

module sfd_decode
    import sfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_dec_out               o_dec
);

    t_mode              r_mode, n_mode;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] count_inc;

    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        o_dec.valid             = 1'b0;
        o_dec.res.kind          = KIND_PAYLOAD;
        o_dec.res.data_byte     = '0;
        o_dec.res.payload_count = r_count;
        case (r_mode)
            MODE_FRAME: begin
                if (i_byte == SLIP_FEND) begin
                    o_dec.valid    = 1'b1;
                    o_dec.res.kind = KIND_END;
                    n_mode         = MODE_HUNT;
                end else if (i_byte == SLIP_FESC) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_dec.valid             = 1'b1;
                    o_dec.res.data_byte     = i_byte;
                    o_dec.res.payload_count = count_inc;
                    n_count                 = count_inc;
                end
            end
            MODE_ESC: begin
                if (i_byte == SLIP_TFEND || i_byte == SLIP_TFESC) begin
                    o_dec.valid             = 1'b1;
                    o_dec.res.data_byte     = (i_byte == SLIP_TFEND) ? SLIP_FEND : SLIP_FESC;
                    o_dec.res.payload_count = count_inc;
                    n_count                 = count_inc;
                    n_mode                  = MODE_FRAME;
                end else begin
                    o_dec.valid    = 1'b1;
                    o_dec.res.kind = KIND_BADESC;
                    n_mode         = MODE_HUNT;
                end
            end
            default: begin
                if (i_byte == SLIP_FEND) begin
                    n_mode  = MODE_FRAME;
                    n_count = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_count <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // opening delimiter restarts the count
    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_mode == MODE_HUNT && i_byte == SLIP_FEND |=> r_count == '0)
        else $error("count not cleared on frame open");

    a_badesc_from_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && o_dec.res.kind == KIND_BADESC |-> r_mode == MODE_ESC)
        else $error("bad escape outside escape state");

    a_payload_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && o_dec.res.kind == KIND_PAYLOAD |-> o_dec.res.payload_count != '0)
        else $error("payload word with zero count");

    a_nonpayload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && o_dec.res.kind != KIND_PAYLOAD |-> o_dec.res.data_byte == '0)
        else $error("status word carries data");

endmodule

`default_nettype wire

// ----- hw/rtl/sfd_out_stage.sv -----
// Result register of the SLIP decoder; frees itself when the sink takes the word.
// Depends on sfd_pkg.
`default_nettype none

module sfd_out_stage
    import sfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_dec_out i_dec,
    output logic          o_take,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_result       o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_take  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load && i_dec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_load && i_dec.valid) begin
            r_res <= i_dec.res;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/slip_frame_decoder.sv -----
// SLIP frame decoder top level: input register, framing decode, result register.
// Depends on sfd_pkg, sfd_byte_if, sfd_result_if, sfd_in_stage, sfd_decode,
// sfd_out_stage.
//
// Usage:
//   i_byte carries received bytes, one word per valid/ready handshake.
//   o_result carries decoded words: kind 0 payload byte, 1 frame end,
//   2 bad escape; payload_count is the frame's byte count, saturating.
//   Bytes outside a frame, the opening delimiter and an escape prefix
//   produce no output word.
// Timing:
//   One byte accepted per cycle while the sink takes each result. A
//   result reaches o_result via the input register, where its byte is
//   held, and then the result register, into which it is decoded.
//   The single decode step between them is what sets the rate.
// Reset:
//   Synchronous, active low; both stages empty, decoder hunting, count zero.
// Stall:
//   A held result blocks the input register, which then blocks i_byte;
//   no word is lost or repeated, and ready recovers in the cycle the sink
//   takes the held word.
`default_nettype none

module slip_frame_decoder
    import sfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfd_byte_if.sink     i_byte,
    sfd_result_if.source o_result
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              take;
    logic              fire;
    t_dec_out          dec;
    t_result           res;

    assign fire = in_valid && take;

    sfd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte.valid),
        .i_byte    (i_byte.in_byte),
        .o_ready   (i_byte.ready),
        .i_advance (take),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    sfd_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (in_byte),
        .o_dec   (dec)
    );

    sfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_valid),
        .i_dec   (dec),
        .o_take  (take),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_res   (res)
    );

    assign o_result.kind          = res.kind;
    assign o_result.data_byte     = res.data_byte;
    assign o_result.payload_count = res.payload_count;

endmodule

`default_nettype wire
